// ----- sv/risc_core_execute_step_core_assert.svh -----
// assertion macros used by the core rtl
`ifndef RISC_CORE_EXECUTE_STEP_CORE_ASSERT_SVH
`define RISC_CORE_EXECUTE_STEP_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("core check failed");

// next-cycle implication, checked outside reset
`define RCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("core check failed");

`endif

// ----- sv/rcstep_pkg.sv -----
// shared types, opcodes and widths for the execute step core
`timescale 1ns / 1ps
package rcstep_pkg;

  localparam int REG_COUNT      = 16;
  localparam int DATA_ADDR_BITS = 20;
  localparam int REG_IDX_W      = $clog2(REG_COUNT);
  localparam int DATA_W         = 32;
  localparam int OP_W           = 8;
  localparam int IMM_W          = 12;
  localparam int MEM_ADDR_W     = 20;
  localparam int SHAMT_W        = 5;
  localparam int MA_BITS        = (DATA_ADDR_BITS < MEM_ADDR_W) ? DATA_ADDR_BITS : MEM_ADDR_W;
  localparam int IN_DATA_W      = 64;
  localparam int OUT_DATA_W     = 128;

  localparam logic [REG_IDX_W-1:0] LINK_REG      = REG_IDX_W'(15);
  localparam logic [REG_IDX_W-1:0] FIRST_WR_REG  = REG_IDX_W'(2);

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD  = 8'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 8'd1;
  localparam logic [OP_W-1:0] OP_AND  = 8'd2;
  localparam logic [OP_W-1:0] OP_OR   = 8'd3;
  localparam logic [OP_W-1:0] OP_XOR  = 8'd4;
  localparam logic [OP_W-1:0] OP_MUL  = 8'd5;
  localparam logic [OP_W-1:0] OP_SLL  = 8'd6;
  localparam logic [OP_W-1:0] OP_SRA  = 8'd7;
  localparam logic [OP_W-1:0] OP_SRL  = 8'd8;
  localparam logic [OP_W-1:0] OP_BEQ  = 8'd9;
  localparam logic [OP_W-1:0] OP_BNE  = 8'd10;
  localparam logic [OP_W-1:0] OP_BLT  = 8'd11;
  localparam logic [OP_W-1:0] OP_BGT  = 8'd12;
  localparam logic [OP_W-1:0] OP_BLE  = 8'd13;
  localparam logic [OP_W-1:0] OP_BGE  = 8'd14;
  localparam logic [OP_W-1:0] OP_JAL  = 8'd15;
  localparam logic [OP_W-1:0] OP_LW   = 8'd16;
  localparam logic [OP_W-1:0] OP_SW   = 8'd17;
  localparam logic [OP_W-1:0] OP_HALT = 8'd20;

  // one decoded instruction
  typedef struct packed {
    logic [OP_W-1:0]      op_code;
    logic [REG_IDX_W-1:0] dest_index;
    logic [REG_IDX_W-1:0] src_a_index;
    logic [REG_IDX_W-1:0] src_b_index;
    logic [IMM_W-1:0]     immediate;
    logic [DATA_W-1:0]    load_data;
  } instr_t;

  // register file write port
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } wr_t;

  // one result item
  typedef struct packed {
    logic [DATA_W-1:0]     next_pc;
    logic                  reg_write_enable;
    logic [REG_IDX_W-1:0]  reg_write_index;
    logic [DATA_W-1:0]     reg_write_value;
    logic                  mem_read_request;
    logic                  mem_write_request;
    logic [MEM_ADDR_W-1:0] data_addr;
    logic [DATA_W-1:0]     store_value;
    logic                  branch_taken;
    logic                  halted;
    logic                  bad_opcode;
  } res_t;

endpackage

// ----- sv/risc_core_execute_step_core.sv -----
// Execute step of a single-issue RISC core: one decoded instruction in,
// one result item out per transfer.
// Input channel s_*: each transfer carries one decoded instruction; the
// register operands are read from the register file as it is taken in.
// Output channel m_*: one result item per instruction with the new pc, the
// register write, the memory request and the branch/halt/bad-opcode flags.
// Path: an instruction is captured in the input register and its operands in the
// register file read registers, then its result goes to the result register.
// Throughput: one instruction per cycle while m_tready is high; the execute
// pass (register operands, alu or 32x32 multiplier, write-back) is combinational
// and a write is forwarded to the operand read of the instruction behind it.
// Reset: pc is zero, the halt flag is clear and all registers read zero
// (per-entry valid bits), both channels are empty.
// Stall: while m_tready is low the result register holds; one more item
// waits in the input register and then s_tready drops until the result
// is taken. After a halt every item returns the held pc with halted set.
`timescale 1ns / 1ps
`include "risc_core_execute_step_core_assert.svh"
module risc_core_execute_step_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // op_code[7:0], dest_index[11:8], src_a_index[15:12], src_b_index[19:16],
  // immediate[31:20], load_data[63:32]
  input  logic [rcstep_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // next_pc[31:0], reg_write_enable[32], reg_write_index[36:33],
  // reg_write_value[68:37], mem_read_request[69], mem_write_request[70],
  // data_addr[90:71], store_value[122:91], branch_taken[123], halted[124],
  // bad_opcode[125], zero[127:126]
  output logic [rcstep_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import rcstep_pkg::*;

  instr_t               in_instr;
  instr_t               instr;
  logic                 in_valid;
  logic                 s_xfer;
  logic                 exec;
  logic [REG_IDX_W-1:0] rd_b_idx;
  logic [DATA_W-1:0]    opnd_a;
  logic [DATA_W-1:0]    opnd_b;
  logic [DATA_W-1:0]    pc;
  logic                 halt_flag;
  res_t                 res_c;
  res_t                 res;
  wr_t                  wr_c;
  wr_t                  wr;
  logic                 halt_set;

  // unpack the incoming instruction
  assign in_instr.op_code     = s_tdata[7:0];
  assign in_instr.dest_index  = s_tdata[11:8];
  assign in_instr.src_a_index = s_tdata[15:12];
  assign in_instr.src_b_index = s_tdata[19:16];
  assign in_instr.immediate   = s_tdata[31:20];
  assign in_instr.load_data   = s_tdata[63:32];

  // handshake: execute when the result register is free or being drained
  assign exec     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || exec;
  assign s_xfer   = s_tvalid && s_tready;

  // store uses the rd register as its second operand
  assign rd_b_idx = (in_instr.op_code == OP_SW) ? in_instr.dest_index : in_instr.src_b_index;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (exec) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      instr <= in_instr;
    end
  end

  assign wr.en   = exec && wr_c.en;
  assign wr.idx  = wr_c.idx;
  assign wr.data = wr_c.data;

  rcstep_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (s_xfer),
    .rd_a_idx  (in_instr.src_a_index),
    .rd_b_idx  (rd_b_idx),
    .wr        (wr),
    .rd_a_data (opnd_a),
    .rd_b_data (opnd_b)
  );

  rcstep_exec u_exec (
    .instr     (instr),
    .opnd_a    (opnd_a),
    .opnd_b    (opnd_b),
    .pc        (pc),
    .halt_flag (halt_flag),
    .res       (res_c),
    .wr        (wr_c),
    .halt_set  (halt_set)
  );

  // architectural pc and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      halt_flag <= 1'b0;
    end else if (exec) begin
      pc        <= res_c.next_pc;
      halt_flag <= halt_flag | halt_set;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res <= res_c;
    end
  end

  // pack the result, first field lowest
  assign m_tdata = {2'b00, res.bad_opcode, res.halted, res.branch_taken, res.store_value,
                    res.data_addr, res.mem_write_request, res.mem_read_request,
                    res.reg_write_value, res.reg_write_index, res.reg_write_enable,
                    res.next_pc};

  // checks
  `RCS_ASSERT_NEXT(a_halt_sticky, clk, rst, halt_flag, halt_flag)
  `RCS_ASSERT_NEXT(a_halt_holds_pc, clk, rst, halt_flag && exec, pc == $past(pc))
  `RCS_ASSERT_NOW(a_no_write_low_regs, clk, rst, wr.en, wr.idx >= FIRST_WR_REG)
  `RCS_ASSERT_NOW(a_stall_cause, clk, rst, !s_tready, in_valid && m_tvalid && !m_tready)

endmodule

// ----- sv/rcstep_regfile.sv -----
// register file: two registered read ports with write bypass, one write port
`timescale 1ns / 1ps
module rcstep_regfile (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rd_en,
  input  logic [rcstep_pkg::REG_IDX_W-1:0]   rd_a_idx,
  input  logic [rcstep_pkg::REG_IDX_W-1:0]   rd_b_idx,
  input  rcstep_pkg::wr_t                    wr,
  output logic [rcstep_pkg::DATA_W-1:0]      rd_a_data,
  output logic [rcstep_pkg::DATA_W-1:0]      rd_b_data
);
  import rcstep_pkg::*;

  logic [DATA_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  // valid bits, an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  // array write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  // registered reads, a write in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.idx == rd_a_idx) begin
        rd_a_data <= wr.data;
      end else if (valid[rd_a_idx]) begin
        rd_a_data <= mem[rd_a_idx];
      end else begin
        rd_a_data <= '0;
      end
      if (wr.en && wr.idx == rd_b_idx) begin
        rd_b_data <= wr.data;
      end else if (valid[rd_b_idx]) begin
        rd_b_data <= mem[rd_b_idx];
      end else begin
        rd_b_data <= '0;
      end
    end
  end

endmodule

// ----- sv/rcstep_exec.sv -----
// execute logic: alu, shifts, branch compare, address add and result build
`timescale 1ns / 1ps
module rcstep_exec (
  input  rcstep_pkg::instr_t              instr,
  input  logic [rcstep_pkg::DATA_W-1:0]   opnd_a,
  input  logic [rcstep_pkg::DATA_W-1:0]   opnd_b,
  input  logic [rcstep_pkg::DATA_W-1:0]   pc,
  input  logic                            halt_flag,
  output rcstep_pkg::res_t                res,
  output rcstep_pkg::wr_t                 wr,
  output logic                            halt_set
);
  import rcstep_pkg::*;

  logic [DATA_W-1:0]    imm_ext;
  logic [DATA_W-1:0]    pc_inc;
  logic [DATA_W-1:0]    addr_sum;
  logic [DATA_W-1:0]    product;
  logic [SHAMT_W-1:0]   shamt;
  logic [DATA_W-1:0]    wv;
  logic [REG_IDX_W-1:0] wi;
  logic                 wanted;
  logic                 cond;
  logic                 cmp_op;

  assign imm_ext  = {{(DATA_W-IMM_W){instr.immediate[IMM_W-1]}}, instr.immediate};
  assign pc_inc   = pc + DATA_W'(1);
  assign addr_sum = opnd_a + imm_ext;
  assign product  = opnd_a * opnd_b;
  assign shamt    = instr.immediate[SHAMT_W-1:0];

  // decode and execute
  always_comb begin
    res       = '0;
    wv        = '0;
    wi        = instr.dest_index;
    wanted    = 1'b0;
    cond      = 1'b0;
    cmp_op    = 1'b0;
    halt_set  = 1'b0;
    res.next_pc = pc_inc;
    case (instr.op_code)
      OP_ADD:  begin wv = opnd_a + opnd_b; wanted = 1'b1; end
      OP_SUB:  begin wv = opnd_a - opnd_b; wanted = 1'b1; end
      OP_AND:  begin wv = opnd_a & opnd_b; wanted = 1'b1; end
      OP_OR:   begin wv = opnd_a | opnd_b; wanted = 1'b1; end
      OP_XOR:  begin wv = opnd_a ^ opnd_b; wanted = 1'b1; end
      OP_MUL:  begin wv = product; wanted = 1'b1; end
      OP_SLL:  begin wv = opnd_b << shamt; wanted = 1'b1; end
      OP_SRA:  begin wv = DATA_W'($signed(opnd_b) >>> shamt); wanted = 1'b1; end
      OP_SRL:  begin wv = opnd_b >> shamt; wanted = 1'b1; end
      OP_BEQ:  begin cmp_op = 1'b1; cond = (opnd_a == opnd_b); end
      OP_BNE:  begin cmp_op = 1'b1; cond = (opnd_a != opnd_b); end
      OP_BLT:  begin cmp_op = 1'b1; cond = ($signed(opnd_a) < $signed(opnd_b)); end
      OP_BGT:  begin cmp_op = 1'b1; cond = ($signed(opnd_a) > $signed(opnd_b)); end
      OP_BLE:  begin cmp_op = 1'b1; cond = ($signed(opnd_a) <= $signed(opnd_b)); end
      OP_BGE:  begin cmp_op = 1'b1; cond = ($signed(opnd_a) >= $signed(opnd_b)); end
      OP_JAL: begin
        res.next_pc      = imm_ext;
        res.branch_taken = 1'b1;
        wi               = LINK_REG;
        wv               = pc_inc;
        wanted           = 1'b1;
      end
      OP_LW: begin
        res.mem_read_request = 1'b1;
        res.data_addr        = MEM_ADDR_W'(addr_sum[MA_BITS-1:0]);
        wv                   = instr.load_data;
        wanted               = 1'b1;
      end
      OP_SW: begin
        res.mem_write_request = 1'b1;
        res.data_addr         = MEM_ADDR_W'(addr_sum[MA_BITS-1:0]);
        res.store_value       = opnd_b;
      end
      OP_HALT: begin
        halt_set   = 1'b1;
        res.halted = 1'b1;
      end
      default: begin
        res.bad_opcode = 1'b1;
      end
    endcase

    // taken branch: word offset from the incremented pc
    if (cmp_op && cond) begin
      res.next_pc      = pc_inc + (imm_ext << 2);
      res.branch_taken = 1'b1;
    end

    // r0 and r1 are read-only
    wr.en   = wanted && (wi >= FIRST_WR_REG);
    wr.idx  = wi;
    wr.data = wv;
    if (wr.en) begin
      res.reg_write_enable = 1'b1;
      res.reg_write_index  = wi;
      res.reg_write_value  = wv;
    end

    // once halted: hold the pc, report halted, change nothing
    if (halt_flag) begin
      res         = '0;
      res.next_pc = pc;
      res.halted  = 1'b1;
      wr          = '0;
      halt_set    = 1'b0;
    end
  end

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the execute step core
`timescale 1ns / 1ps
module tb;
  import rcstep_pkg::*;

  localparam int IDLE_PCT     = 22;    // chance in a hundred that a side idles
  localparam int QUIET_LO     = 350;   // stretch with no idling on either side
  localparam int QUIET_HI     = 450;
  localparam int HOLD_AT      = 120;   // receiver hold-off starts after this many results
  localparam int HOLD_LEN     = 80;
  localparam int DRAIN_AT     = 250;   // sender waits for all results before this item
  localparam int RANDOM_ITEMS = 550;
  localparam int SETTLE       = 10;    // margin after the last result has been checked
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    instr_t ins;
    bit     drain_first;
  } pending_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // architectural state mirrored by the predictor
  logic [DATA_W-1:0] arch_regs [REG_COUNT];
  logic [DATA_W-1:0] arch_pc;
  logic              arch_halted;

  pending_t pending_q[$];
  res_t     retire_q[$];
  instr_t   cur_instr;
  pending_t nxt;
  res_t     got_res;
  res_t     want_res;
  bit       go;
  int       n_total;
  int       n_issued;
  int       n_checked;
  int       n_errors;
  int       hold_left;
  bit       hold_done;
  int       stall_cycles;

  risc_core_execute_step_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // executes one instruction against the mirrored state
  function automatic res_t execute_instr(instr_t ins);
    res_t              r;
    logic [DATA_W-1:0] a, b, c, imm, pc_inc, wv, sum;
    logic [4:0]        sh;
    logic [3:0]        rd;
    logic              wanted, cond;
    r = '0;
    if (arch_halted) begin
      r.next_pc = arch_pc;
      r.halted  = 1'b1;
      return r;
    end
    a      = arch_regs[ins.src_a_index];
    b      = arch_regs[ins.src_b_index];
    c      = arch_regs[ins.dest_index];
    imm    = {{(DATA_W-IMM_W){ins.immediate[IMM_W-1]}}, ins.immediate};
    sum    = a + imm;
    sh     = imm[4:0];
    pc_inc = arch_pc + 1;
    rd     = ins.dest_index;
    wv     = '0;
    wanted = 1'b0;
    cond   = 1'b0;
    r.next_pc = pc_inc;
    case (ins.op_code)
      OP_ADD: begin wv = a + b; wanted = 1'b1; end
      OP_SUB: begin wv = a - b; wanted = 1'b1; end
      OP_AND: begin wv = a & b; wanted = 1'b1; end
      OP_OR:  begin wv = a | b; wanted = 1'b1; end
      OP_XOR: begin wv = a ^ b; wanted = 1'b1; end
      OP_MUL: begin wv = a * b; wanted = 1'b1; end
      OP_SLL: begin wv = b << sh; wanted = 1'b1; end
      OP_SRA: begin wv = $signed(b) >>> sh; wanted = 1'b1; end
      OP_SRL: begin wv = b >> sh; wanted = 1'b1; end
      OP_BEQ: cond = (a == b);
      OP_BNE: cond = (a != b);
      OP_BLT: cond = ($signed(a) < $signed(b));
      OP_BGT: cond = ($signed(a) > $signed(b));
      OP_BLE: cond = ($signed(a) <= $signed(b));
      OP_BGE: cond = ($signed(a) >= $signed(b));
      OP_JAL: begin
        r.next_pc      = imm;
        r.branch_taken = 1'b1;
        rd             = LINK_REG;
        wv             = pc_inc;
        wanted         = 1'b1;
      end
      OP_LW: begin
        r.mem_read_request = 1'b1;
        r.data_addr        = MEM_ADDR_W'(sum[MA_BITS-1:0]);
        wv                 = ins.load_data;
        wanted             = 1'b1;
      end
      OP_SW: begin
        r.mem_write_request = 1'b1;
        r.data_addr         = MEM_ADDR_W'(sum[MA_BITS-1:0]);
        r.store_value       = c;
      end
      OP_HALT: arch_halted = 1'b1;
      default: r.bad_opcode = 1'b1;
    endcase
    // taken compare branch: offset counted in words from the incremented pc
    if (cond) begin
      r.next_pc      = pc_inc + (imm << 2);
      r.branch_taken = 1'b1;
    end
    // r0 and r1 stay zero
    if (wanted && rd >= FIRST_WR_REG) begin
      arch_regs[rd]     = wv;
      r.reg_write_enable = 1'b1;
      r.reg_write_index  = rd;
      r.reg_write_value  = wv;
    end
    arch_pc  = r.next_pc;
    r.halted = arch_halted;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_instr(instr_t i);
    return {i.load_data, i.immediate, i.src_b_index, i.src_a_index, i.dest_index, i.op_code};
  endfunction

  function automatic res_t unpack_result(logic [OUT_DATA_W-1:0] d);
    res_t r;
    r.next_pc           = d[31:0];
    r.reg_write_enable  = d[32];
    r.reg_write_index   = d[36:33];
    r.reg_write_value   = d[68:37];
    r.mem_read_request  = d[69];
    r.mem_write_request = d[70];
    r.data_addr         = d[90:71];
    r.store_value       = d[122:91];
    r.branch_taken      = d[123];
    r.halted            = d[124];
    r.bad_opcode        = d[125];
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void compare_result(res_t want, res_t got);
    check_field("next_pc", want.next_pc, got.next_pc);
    check_field("reg_write_enable", want.reg_write_enable, got.reg_write_enable);
    check_field("reg_write_index", want.reg_write_index, got.reg_write_index);
    check_field("reg_write_value", want.reg_write_value, got.reg_write_value);
    check_field("mem_read_request", want.mem_read_request, got.mem_read_request);
    check_field("mem_write_request", want.mem_write_request, got.mem_write_request);
    check_field("data_addr", want.data_addr, got.data_addr);
    check_field("store_value", want.store_value, got.store_value);
    check_field("branch_taken", want.branch_taken, got.branch_taken);
    check_field("halted", want.halted, got.halted);
    check_field("bad_opcode", want.bad_opcode, got.bad_opcode);
  endfunction

  function automatic instr_t mk(logic [OP_W-1:0] op, int rd, int rs, int rt, int imm,
                                logic [DATA_W-1:0] ld);
    instr_t i;
    i.op_code     = op;
    i.dest_index  = REG_IDX_W'(rd);
    i.src_a_index = REG_IDX_W'(rs);
    i.src_b_index = REG_IDX_W'(rt);
    i.immediate   = IMM_W'(imm);
    i.load_data   = ld;
    return i;
  endfunction

  // data words biased toward the corners
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return DATA_W'($urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // mostly loads and alu ops so registers carry live values, some branches,
  // jumps and stores, a little noise with unknown opcodes
  function automatic instr_t random_instr();
    instr_t      i;
    int unsigned pick;
    i.dest_index  = REG_IDX_W'($urandom_range(15));
    i.src_a_index = REG_IDX_W'($urandom_range(15));
    i.src_b_index = REG_IDX_W'($urandom_range(15));
    i.immediate   = IMM_W'($urandom_range(4095));
    i.load_data   = pick_word();
    pick = $urandom_range(99);
    if (pick < 22)      i.op_code = OP_LW;
    else if (pick < 62) i.op_code = OP_W'($urandom_range(OP_SRL, OP_ADD));
    else if (pick < 80) i.op_code = OP_W'($urandom_range(OP_BGE, OP_BEQ));
    else if (pick < 85) i.op_code = OP_JAL;
    else if (pick < 93) i.op_code = OP_SW;
    else if (pick < 95) i.op_code = OP_W'($urandom_range(OP_HALT - 1, OP_SW + 1));
    else                i.op_code = OP_W'($urandom_range(255, OP_HALT + 1));
    return i;
  endfunction

  function automatic void queue_instr(instr_t i, bit drain_first);
    pending_t p;
    p.ins         = i;
    p.drain_first = drain_first;
    pending_q.push_back(p);
  endfunction

  // stimulus and end of run
  initial begin
    for (int k = 0; k < REG_COUNT; k++) arch_regs[k] = '0;
    arch_pc     = '0;
    arch_halted = 1'b0;

    // directed: operand corners, every operation, dropped writes, unknown opcodes
    queue_instr(mk(OP_LW, 2, 0, 0, 0, 32'hffff_ffff), 0);
    queue_instr(mk(OP_LW, 3, 0, 0, 2047, 32'h8000_0000), 0);
    queue_instr(mk(OP_LW, 4, 2, 0, -2048, 32'h7fff_ffff), 0);
    queue_instr(mk(OP_LW, 0, 0, 0, 5, 32'h1234_5678), 0);
    queue_instr(mk(OP_ADD, 1, 2, 2, 0, '0), 0);
    queue_instr(mk(OP_ADD, 5, 2, 4, 0, '0), 0);
    queue_instr(mk(OP_SUB, 6, 3, 4, 0, '0), 0);
    queue_instr(mk(OP_AND, 7, 2, 3, 0, '0), 0);
    queue_instr(mk(OP_OR, 8, 3, 4, 0, '0), 0);
    queue_instr(mk(OP_XOR, 9, 2, 3, 0, '0), 0);
    queue_instr(mk(OP_MUL, 10, 2, 4, 0, '0), 0);
    queue_instr(mk(OP_SLL, 11, 0, 2, 31, '0), 0);
    queue_instr(mk(OP_SRA, 12, 0, 3, -1, '0), 0);
    queue_instr(mk(OP_SRA, 13, 0, 3, 32, '0), 0);
    queue_instr(mk(OP_SRL, 14, 0, 2, 1, '0), 0);
    queue_instr(mk(OP_BEQ, 0, 0, 1, -2048, '0), 0);
    queue_instr(mk(OP_BNE, 0, 2, 2, 7, '0), 0);
    queue_instr(mk(OP_BNE, 0, 2, 3, 2047, '0), 0);
    queue_instr(mk(OP_BLT, 0, 3, 4, -3, '0), 0);
    queue_instr(mk(OP_BGT, 0, 3, 4, 3, '0), 0);
    queue_instr(mk(OP_BLE, 0, 5, 5, 1, '0), 0);
    queue_instr(mk(OP_BGE, 0, 3, 2, 9, '0), 0);
    queue_instr(mk(OP_JAL, 7, 0, 0, -2048, '0), 0);
    queue_instr(mk(OP_JAL, 0, 0, 0, 2047, '0), 0);
    queue_instr(mk(OP_SW, 15, 2, 0, 1, '0), 0);
    queue_instr(mk(OP_SW, 3, 4, 0, -2048, '0), 0);
    queue_instr(mk(8'hff, 9, 2, 3, -1, '1), 0);
    queue_instr(mk(OP_SW + 1, 4, 4, 4, 0, '0), 0);

    for (int k = 0; k < RANDOM_ITEMS; k++) queue_instr(random_instr(), k == DRAIN_AT);

    // halt, then items that must change nothing
    queue_instr(mk(OP_HALT, 0, 0, 0, 0, '0), 1);
    queue_instr(mk(OP_ADD, 5, 2, 2, 0, '0), 0);
    queue_instr(mk(OP_JAL, 0, 0, 0, 100, '0), 0);
    queue_instr(mk(OP_LW, 6, 0, 0, 4, 32'hdead_beef), 0);
    queue_instr(mk(OP_HALT, 0, 0, 0, 0, '0), 0);
    n_total = pending_q.size();

    wait (n_checked >= n_total);
    repeat (SETTLE) @(posedge clk);
    if (retire_q.size() != 0) begin
      $error("%0d expected results never arrived", retire_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // instruction driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        retire_q.push_back(execute_instr(cur_instr));
        n_issued++;
      end
      if (!s_tvalid || s_tready) begin
        go = 1'b0;
        if (pending_q.size() > 0) begin
          if (pending_q[0].drain_first && n_checked != n_issued) go = 1'b0;
          else if (n_issued >= QUIET_LO && n_issued < QUIET_HI) go = 1'b1;
          else go = ($urandom_range(99) >= IDLE_PCT);
        end
        if (go) begin
          nxt       = pending_q.pop_front();
          cur_instr = nxt.ins;
          s_tdata  <= pack_instr(cur_instr);
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res = unpack_result(m_tdata);
        if (retire_q.size() == 0) begin
          $error("result transfer with no expected result, next_pc %h", got_res.next_pc);
          n_errors++;
        end else begin
          want_res = retire_q.pop_front();
          compare_result(want_res, got_res);
        end
        n_checked++;
      end
      // one long hold-off so the core fills up and stalls its input
      if (!hold_done && n_checked >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (n_checked >= QUIET_LO && n_checked < QUIET_HI) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
